// ===== sv/sfr_pkg.sv =====
`default_nettype none

package sfr_pkg;

    localparam int MAX_FRAME_DEF = 64;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 7;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OVH_W      = 4;
    localparam int POLL_W     = 16;
    localparam int POLL_CNT_W = 17;
    localparam int OFS_W      = 6;
    localparam int SUM_W      = 9;

    typedef enum logic [STATUS_W-1:0] {
        ST_FRAME    = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_NOSYNC   = 3'd3,
        ST_ROUTED   = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_FIRST     = 3'd0,
        CFG_SYNC_SECOND    = 3'd1,
        CFG_FRAME_OVERHEAD = 3'd2,
        CFG_POLL_LIMIT     = 3'd3,
        CFG_ROUTING_ENABLE = 3'd4
    } cfg_index_t;

    localparam logic [OVH_W-1:0]  OVH_RESET        = 4'd4;
    localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 16'hFFFF;

    localparam logic [BYTE_W-1:0] PATCH_FROM   = 8'hA8;
    localparam logic [BYTE_W-1:0] PATCH_TO     = 8'hA1;
    localparam logic [BYTE_W-1:0] ROUTE_MARK_A = 8'hFF;
    localparam logic [BYTE_W-1:0] ROUTE_MARK_B = 8'hFA;
    localparam logic [BYTE_W-1:0] ROUTE_MARK_C = 8'hFB;
    localparam logic [BYTE_W-1:0] ROUTE_PORT_A = 8'h0A;
    localparam logic [BYTE_W-1:0] ROUTE_PORT_B = 8'h0B;

    typedef struct packed {
        logic idle;
        logic advance;
        logic load_status;
        logic start_run;
        logic read_entry;
        logic load_byte;
        logic end_rx;
    } sfr_cmd_t;

    typedef struct packed {
        logic item_taken;
        logic need_status;
        logic run_ready;
        logic slot_free;
        logic run_last;
    } sfr_stat_t;

endpackage

`default_nettype wire

// ===== sv/sfr_item_if.sv =====
`default_nettype none

interface sfr_item_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [sfr_pkg::BYTE_W-1:0]  rx_byte;
    logic                        batch_end;

    modport source (output valid, output operation, output rx_byte, output batch_end,
                    input ready);
    modport sink   (input valid, input operation, input rx_byte, input batch_end,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/sfr_result_if.sv =====
`default_nettype none

interface sfr_result_if;
    logic                         valid;
    logic                         ready;
    logic [sfr_pkg::STATUS_W-1:0] status;
    logic [sfr_pkg::BYTE_W-1:0]   frame_byte;
    logic [sfr_pkg::LEN_W-1:0]    frame_length;
    logic                         last;

    modport source (output valid, output status, output frame_byte, output frame_length,
                    output last, input ready);
    modport sink   (input valid, input status, input frame_byte, input frame_length,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== sv/sfr_datapath.sv =====
`default_nettype none

module sfr_datapath #(
    parameter int MAX_FRAME = sfr_pkg::MAX_FRAME_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
    sfr_item_if.sink                            item_chan,
    sfr_result_if.source                        result_chan,
    input  wire sfr_pkg::sfr_cmd_t              cmd,
    output sfr_pkg::sfr_stat_t                  stat
);
    import sfr_pkg::*;

    localparam int AW  = $clog2(MAX_FRAME);
    localparam int WIW = $clog2(MAX_FRAME + 1);

    typedef enum logic [1:0] {
        PH_HUNT1  = 2'd0,
        PH_HUNT2  = 2'd1,
        PH_LENGTH = 2'd2,
        PH_BODY   = 2'd3
    } phase_t;

    logic [BYTE_W-1:0]     sync_first_reg;
    logic [BYTE_W-1:0]     sync_second_reg;
    logic [OVH_W-1:0]      overhead_reg;
    logic [POLL_W-1:0]     poll_limit_reg;
    logic                  routing_en_reg;

    logic [BYTE_W-1:0]     store_mem [MAX_FRAME];
    logic [BYTE_W-1:0]     rd_data_reg;
    logic [BYTE_W-1:0]     entry1_reg;
    logic [BYTE_W-1:0]     entry2_reg;

    logic [WIW-1:0]        wi_reg;
    logic [OFS_W-1:0]      ofs_reg;
    logic [BYTE_W-1:0]     len_reg;
    phase_t                phase_reg;
    logic [POLL_CNT_W-1:0] poll_reg;
    logic                  mid_reg;
    logic                  op_reg;
    logic                  bend_reg;
    logic                  pend_timeout_reg;
    logic                  pend_overflow_reg;
    logic                  check_reg;
    logic [WIW-1:0]        k_reg;

    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic [LEN_W-1:0]      out_len_reg;
    logic                  out_last_reg;

    logic                  accept;
    logic                  poll_start;
    logic [POLL_CNT_W-1:0] poll_next;
    logic                  timeout_hit;
    logic                  store_full;
    logic                  byte_go;
    logic                  routing_hit;
    logic [SUM_W-1:0]      end_index;
    logic                  complete;
    logic                  batch_close;
    logic                  need_status;
    status_t               status_code;
    logic                  slot_free;
    logic                  run_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= '0;
            sync_second_reg <= '0;
            overhead_reg    <= OVH_RESET;
            poll_limit_reg  <= POLL_LIMIT_RESET;
            routing_en_reg  <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:     sync_first_reg  <= cfg_data[BYTE_W-1:0];
                CFG_SYNC_SECOND:    sync_second_reg <= cfg_data[BYTE_W-1:0];
                CFG_FRAME_OVERHEAD: overhead_reg    <= cfg_data[OVH_W-1:0];
                CFG_POLL_LIMIT:     poll_limit_reg  <= cfg_data[POLL_W-1:0];
                CFG_ROUTING_ENABLE: routing_en_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign accept      = item_chan.valid && cmd.idle;
    assign poll_start  = item_chan.operation || !mid_reg;
    assign poll_next   = poll_reg + POLL_CNT_W'(1);
    assign timeout_hit = poll_start && (poll_next > {1'b0, poll_limit_reg});
    assign store_full  = wi_reg >= WIW'(MAX_FRAME);
    assign byte_go     = accept && !timeout_hit && !item_chan.operation && !store_full;

    assign routing_hit = routing_en_reg
                         && (entry1_reg == ROUTE_MARK_A || entry1_reg == ROUTE_MARK_B
                             || entry1_reg == ROUTE_MARK_C)
                         && (entry2_reg == ROUTE_PORT_A || entry2_reg == ROUTE_PORT_B);

    assign end_index   = SUM_W'(len_reg) + SUM_W'(overhead_reg) + SUM_W'(ofs_reg);
    assign complete    = check_reg && (SUM_W'(wi_reg) >= end_index);
    assign batch_close = op_reg || bend_reg;

    always_comb
    begin
        need_status = 1'b0;
        status_code = ST_NOSYNC;
        if (pend_timeout_reg)
        begin
            need_status = 1'b1;
            status_code = ST_TIMEOUT;
        end
        else if (pend_overflow_reg)
        begin
            need_status = 1'b1;
            status_code = ST_OVERFLOW;
        end
        else if (!complete && batch_close)
        begin
            if (phase_reg == PH_HUNT1)
            begin
                need_status = 1'b1;
                status_code = routing_hit ? ST_ROUTED : ST_NOSYNC;
            end
            else if (phase_reg == PH_BODY && routing_hit)
            begin
                need_status = 1'b1;
                status_code = ST_ROUTED;
            end
        end
    end

    assign slot_free = !out_valid_reg || result_chan.ready;
    assign run_last  = k_reg == wi_reg;

    assign stat.item_taken  = accept;
    assign stat.need_status = need_status;
    assign stat.run_ready   = complete;
    assign stat.slot_free   = slot_free;
    assign stat.run_last    = run_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg            <= '0;
            ofs_reg           <= '0;
            len_reg           <= '0;
            phase_reg         <= PH_HUNT1;
            poll_reg          <= '0;
            mid_reg           <= 1'b0;
            op_reg            <= 1'b0;
            bend_reg          <= 1'b0;
            pend_timeout_reg  <= 1'b0;
            pend_overflow_reg <= 1'b0;
            check_reg         <= 1'b0;
        end
        else if (cmd.end_rx)
        begin
            wi_reg    <= '0;
            ofs_reg   <= '0;
            len_reg   <= '0;
            phase_reg <= PH_HUNT1;
            poll_reg  <= '0;
            mid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                op_reg            <= item_chan.operation;
                bend_reg          <= item_chan.batch_end;
                pend_timeout_reg  <= timeout_hit;
                pend_overflow_reg <= !timeout_hit && !item_chan.operation && store_full;
                check_reg         <= byte_go && (phase_reg == PH_BODY);
                if (poll_start)
                begin
                    poll_reg <= poll_next;
                end
                if (!timeout_hit && !item_chan.operation)
                begin
                    mid_reg <= 1'b1;
                    if (!store_full)
                    begin
                        unique case (phase_reg)
                            PH_HUNT1:
                            begin
                                if (item_chan.rx_byte == sync_first_reg)
                                begin
                                    phase_reg <= PH_HUNT2;
                                    ofs_reg   <= OFS_W'(wi_reg);
                                end
                            end
                            PH_HUNT2:
                            begin
                                if (item_chan.rx_byte == sync_second_reg)
                                begin
                                    phase_reg <= PH_LENGTH;
                                end
                            end
                            PH_LENGTH:
                            begin
                                len_reg   <= item_chan.rx_byte;
                                phase_reg <= PH_BODY;
                            end
                            PH_BODY:
                            begin
                                if (entry2_reg == PATCH_FROM)
                                begin
                                    len_reg <= PATCH_TO;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            if (cmd.advance)
            begin
                if (!op_reg)
                begin
                    wi_reg <= wi_reg + WIW'(1);
                end
                if (batch_close)
                begin
                    mid_reg <= 1'b0;
                end
            end
        end
    end

    // frame store, single write and single registered read
    always_ff @(posedge clk)
    begin
        if (byte_go)
        begin
            store_mem[wi_reg[AW-1:0]] <= item_chan.rx_byte;
        end
        if (cmd.read_entry)
        begin
            rd_data_reg <= store_mem[k_reg[AW-1:0]];
        end
    end

    // copies of entries 1 and 2 for the routing check and the patch
    always_ff @(posedge clk)
    begin
        if (byte_go && wi_reg == WIW'(1))
        begin
            entry1_reg <= item_chan.rx_byte;
        end
        if (byte_go && wi_reg == WIW'(2))
        begin
            entry2_reg <= item_chan.rx_byte;
        end
        else if (byte_go && phase_reg == PH_BODY && entry2_reg == PATCH_FROM)
        begin
            entry2_reg <= PATCH_TO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start_run)
            begin
                k_reg <= '0;
            end
            else if (cmd.load_byte)
            begin
                k_reg <= k_reg + WIW'(1);
            end
            if (cmd.load_status || cmd.load_byte)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_status)
        begin
            out_status_reg <= status_code;
            out_byte_reg   <= '0;
            out_len_reg    <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.load_byte)
        begin
            out_status_reg <= ST_FRAME;
            out_byte_reg   <= (k_reg == WIW'(2)) ? entry2_reg : rd_data_reg;
            out_len_reg    <= run_last ? LEN_W'(wi_reg) + LEN_W'(1) : '0;
            out_last_reg   <= run_last;
        end
    end

    assign item_chan.ready          = cmd.idle;
    assign result_chan.valid        = out_valid_reg;
    assign result_chan.status       = out_status_reg;
    assign result_chan.frame_byte   = out_byte_reg;
    assign result_chan.frame_length = out_len_reg;
    assign result_chan.last         = out_last_reg;

`ifndef NO_ASSERTIONS
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wi_reg <= WIW'(MAX_FRAME))
        else $error("write index beyond frame store");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_status || cmd.load_byte) |-> slot_free)
        else $error("result register loaded while still full");

    a_offset_order: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(ofs_reg) <= SUM_W'(wi_reg))
        else $error("sync offset ahead of write index");

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_byte |-> k_reg <= wi_reg)
        else $error("frame run read past last stored byte");

    a_check_clean: assert property (@(posedge clk) disable iff (!rst_n)
        check_reg |-> (!pend_timeout_reg && !pend_overflow_reg))
        else $error("completion check armed with a pending status");
`endif

endmodule

`default_nettype wire

// ===== sv/sfr_ctrl.sv =====
`default_nettype none

module sfr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sfr_pkg::sfr_stat_t stat,
    output sfr_pkg::sfr_cmd_t       cmd
);
    import sfr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EVAL = 2'd1,
        S_READ = 2'd2,
        S_LOAD = 2'd3
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (stat.item_taken)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (stat.run_ready)
                begin
                    cmd.start_run = 1'b1;
                    state_next    = S_READ;
                end
                else if (stat.need_status)
                begin
                    if (stat.slot_free)
                    begin
                        cmd.load_status = 1'b1;
                        cmd.end_rx      = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.read_entry = 1'b1;
                state_next     = S_LOAD;
            end
            S_LOAD:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_byte = 1'b1;
                    if (stat.run_last)
                    begin
                        cmd.end_rx = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/serial_frame_receiver_unit.sv =====
// Framed serial receiver: bytes arrive in polling batches and are stored at a running
// index; after two sync bytes the next byte gives the length, and once the index reaches
// length + overhead + sync offset the whole stored frame is sent out as a run of items,
// the length on the last one. Timeout, overflow, no sync and routed-elsewhere outcomes are
// single status items. Each input item is accepted and then evaluated, and the evaluation
// waits for the result register when a status item is due. After the last byte of a
// completed frame is taken come an evaluation step, then a registered frame store read
// and a result load for each byte, with each load waiting while the result register is
// full; no input item is taken during the run. A new item is taken while an earlier
// result still waits in the output register.
`default_nettype none

module serial_frame_receiver_unit #(
    parameter int MAX_FRAME = sfr_pkg::MAX_FRAME_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
    sfr_item_if.sink                            item_chan,
    sfr_result_if.source                        result_chan
);
    import sfr_pkg::*;

    sfr_cmd_t  cmd;
    sfr_stat_t stat;

    sfr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    sfr_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_chan    (item_chan),
        .result_chan  (result_chan),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

`default_nettype wire
